// ===== hw/rtl/mwo_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mwo_pkg;

   // Field widths of the ports.
   localparam int PHASE_W     = 23;
   localparam int FREQ_W      = 22;
   localparam int GAIN_W      = 16;
   localparam int WAVE_W      = 2;
   localparam int SAMPLE_W    = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 22;

   // Defaults for the top-level parameters.
   localparam int DEFAULT_SAMPLE_HZ        = 48000;
   localparam int DEFAULT_SINE_TABLE_DEPTH = 1024;
   localparam int DEFAULT_FRACTION_BITS    = 16;

   // Register values after reset.
   localparam logic [FREQ_W-1:0]        FREQ_RESET = FREQ_W'(44000);
   localparam logic signed [GAIN_W-1:0] GAIN_RESET = '0;
   localparam logic [WAVE_W-1:0]        WAVE_RESET = '0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FREQ = 2'd0,
      CSR_GAIN = 2'd1,
      CSR_WAVE = 2'd2
   } csr_index_type;

   localparam logic [WAVE_W-1:0] WAVE_SINE     = 2'd0;
   localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 2'd1;
   localparam logic [WAVE_W-1:0] WAVE_SAWTOOTH = 2'd2;

   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_LOAD = 1'b1;

   // Odd polynomial for sin(pi/2 * a) in Q30.
   localparam longint unsigned Q30_ONE_HALF = 64'd536870912;
   localparam longint unsigned SIN_C1       = 64'd1686629713;
   localparam longint unsigned SIN_C3       = 64'd693598668;
   localparam longint unsigned SIN_C5       = 64'd85569306;
   localparam longint unsigned SIN_C7       = 64'd5026996;
   localparam longint unsigned SIN_C9       = 64'd172272;

   typedef struct packed {
      logic               req_type;
      logic [PHASE_W-1:0] new_phase;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_out;
      logic [PHASE_W-1:0]         phase_now;
   } rsp_payload_type;

endpackage

`default_nettype wire

// ===== hw/rtl/mwo_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mwo_divider #(
   parameter int DIVIDEND_W = 25,
   parameter int DIVISOR_W  = 25,
   parameter int QUOT_W     = 25,
   parameter int COUNT_W    = 5
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  init_rem,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   input  wire logic [COUNT_W-1:0]    iterations,
   output logic                       done,
   output logic [QUOT_W-1:0]          quotient,
   output logic [DIVISOR_W-1:0]       remainder
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [DIVIDEND_W-1:0] dvd_ff, dvd_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;
   logic [QUOT_W-1:0]     quo_ff, quo_in;

   logic [DIVISOR_W:0] partial;
   logic [DIVISOR_W:0] diff;
   logic               fits;

   // One restoring step: bring down the next dividend bit and subtract if it fits.
   always_comb begin
      partial = {rem_ff, dvd_ff[DIVIDEND_W-1]};
      diff    = partial - {1'b0, divisor_ff};
      fits    = partial >= {1'b0, divisor_ff};

      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      dvd_in     = dvd_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      quo_in     = quo_ff;

      if (start) begin
         busy_in    = 1'b1;
         count_in   = iterations;
         dvd_in     = dividend;
         rem_in     = init_rem;
         divisor_in = divisor;
         quo_in     = '0;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[DIVISOR_W-1:0] : partial[DIVISOR_W-1:0];
         quo_in   = {quo_ff[QUOT_W-2:0], fits};
         dvd_in   = dvd_ff << 1;
         count_in = count_ff - COUNT_W'(1);
         if (count_ff == COUNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff   <= count_in;
      dvd_ff     <= dvd_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      quo_ff     <= quo_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/multiwave_oscillator_unit.sv =====
// Sequence: a sample tick runs the divider passes for the period, the phase modulo the period
// and the fraction, then the states ST_POSITION, ST_QUADRANT, ST_LOOKUP, ST_VALUE and ST_SCALE
// to ST_RESULT. A zero period ends after the first division.
// Load items and zero-frequency ticks register their result one cycle after acceptance.
// Throughput: one item at a time; the next item is taken once the result is registered, and a
// result waits in ST_RESULT while the previous one is unread. Reset (synchronous): phase 0,
// frequency 440.00 Hz, gain 0, sine wave, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module multiwave_oscillator_unit
   import mwo_pkg::*;
#(
   parameter int SAMPLE_HZ        = DEFAULT_SAMPLE_HZ,
   parameter int SINE_TABLE_DEPTH = DEFAULT_SINE_TABLE_DEPTH,
   parameter int FRACTION_BITS    = DEFAULT_FRACTION_BITS
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire req_payload_type         req_payload,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output rsp_payload_type              rsp_payload,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_data
);

   localparam int FB         = FRACTION_BITS;
   localparam int NUM        = SAMPLE_HZ * 100;
   localparam int PERIOD_W   = $clog2(NUM + 1);
   localparam int DIVISOR_W  = (FREQ_W > PERIOD_W) ? FREQ_W : PERIOD_W;
   localparam int DIVIDEND_W = (PHASE_W > PERIOD_W) ? PHASE_W : PERIOD_W;
   localparam int QUOT_W     = (FB > PERIOD_W) ? FB : PERIOD_W;
   localparam int ITER_A     = (PHASE_W > PERIOD_W) ? PHASE_W : PERIOD_W;
   localparam int ITER_MAX   = (FB > ITER_A) ? FB : ITER_A;
   localparam int COUNT_W    = $clog2(ITER_MAX + 1);

   localparam int POS_W    = $clog2(4 * SINE_TABLE_DEPTH);
   localparam int POSMUL_W = FB + $clog2(4 * SINE_TABLE_DEPTH + 1);
   localparam int IDX_W    = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int VAL_W    = 17;
   localparam int V_W      = FB + 2;
   localparam int SCL_W    = FB + 17;
   localparam int PROD_W   = VAL_W + GAIN_W;

   localparam logic [V_W-1:0]   FULL      = V_W'(1) << FB;
   localparam logic [SCL_W-1:0] TRUNC_ADJ = (SCL_W'(1) << FB) - SCL_W'(1);

   typedef logic [SAMPLE_W-1:0] sine_rom_type [0:SINE_TABLE_DEPTH];

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type    rom;
      longint unsigned a, a2, s, r, v;
      for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
         a  = (longint'(i) << 30) / SINE_TABLE_DEPTH;
         a2 = (a * a) >> 30;
         s  = SIN_C9;
         s  = SIN_C7 - ((a2 * s) >> 30);
         s  = SIN_C5 - ((a2 * s) >> 30);
         s  = SIN_C3 - ((a2 * s) >> 30);
         s  = SIN_C1 - ((a2 * s) >> 30);
         r  = (a * s) >> 30;
         v  = (r * 64'd32768 + Q30_ONE_HALF) >> 30;
         if (v > 64'd32768) begin
            v = 64'd32768;
         end
         rom[i] = SAMPLE_W'(v);
      end
      return rom;
   endfunction

   localparam sine_rom_type SineRom = build_sine_rom();

   typedef enum logic [9:0] {
      ST_IDLE     = 10'b0000000001,
      ST_PERIOD   = 10'b0000000010,
      ST_MODULO   = 10'b0000000100,
      ST_FRACTION = 10'b0000001000,
      ST_POSITION = 10'b0000010000,
      ST_QUADRANT = 10'b0000100000,
      ST_LOOKUP   = 10'b0001000000,
      ST_VALUE    = 10'b0010000000,
      ST_SCALE    = 10'b0100000000,
      ST_RESULT   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   logic [FREQ_W-1:0]        freq_ff, freq_in;
   logic signed [GAIN_W-1:0] gain_ff, gain_in;
   logic [WAVE_W-1:0]        wave_ff, wave_in;

   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic                silent_ff, silent_in;
   logic [FB-1:0]       frac_ff, frac_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [IDX_W-1:0]    rom_addr_ff, rom_addr_in;
   logic                neg_ff, neg_in;
   logic [SAMPLE_W-1:0] rom_data_ff;
   logic signed [VAL_W-1:0]  value_ff, value_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic                  div_start;
   logic [DIVIDEND_W-1:0] div_dividend;
   logic [DIVISOR_W-1:0]  div_init_rem;
   logic [DIVISOR_W-1:0]  div_divisor;
   logic [COUNT_W-1:0]    div_iterations;
   logic                  div_done;
   logic [QUOT_W-1:0]     div_quotient;
   logic [DIVISOR_W-1:0]  div_remainder;

   logic [PERIOD_W-1:0] period_now;
   logic [PERIOD_W-1:0] rem_now;
   logic [PERIOD_W-1:0] rem_plus;
   logic [PERIOD_W-1:0] phase_next;

   logic [POSMUL_W-1:0]   pos_prod;
   logic signed [V_W-1:0] saw_v, tri_abs, tri_v;
   logic signed [SCL_W-1:0] saw_scaled, tri_scaled, saw_biased, tri_biased;
   logic signed [VAL_W-1:0] saw_q15, tri_q15, sine_q15;

   logic signed [PROD_W-1:0]   prod_biased;
   logic signed [PROD_W-13:0]  prod_div;
   logic signed [SAMPLE_W-1:0] sample_sat;

   logic req_fire;

   mwo_divider #(
      .DIVIDEND_W (DIVIDEND_W),
      .DIVISOR_W  (DIVISOR_W),
      .QUOT_W     (QUOT_W),
      .COUNT_W    (COUNT_W)
   ) u_divider (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .dividend   (div_dividend),
      .init_rem   (div_init_rem),
      .divisor    (div_divisor),
      .iterations (div_iterations),
      .done       (div_done),
      .quotient   (div_quotient),
      .remainder  (div_remainder)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign period_now = div_quotient[PERIOD_W-1:0];
   assign rem_now    = div_remainder[PERIOD_W-1:0];
   assign rem_plus   = rem_now + PERIOD_W'(1);
   assign phase_next = (rem_plus == period_ff) ? '0 : rem_plus;

   // Divider operands: period first, then phase modulo period, then the fraction.
   always_comb begin
      div_dividend   = DIVIDEND_W'(NUM) << (DIVIDEND_W - PERIOD_W);
      div_init_rem   = '0;
      div_divisor    = DIVISOR_W'(freq_ff);
      div_iterations = COUNT_W'(PERIOD_W);
      case (state_ff)
         ST_PERIOD: begin
            div_dividend   = DIVIDEND_W'(phase_ff) << (DIVIDEND_W - PHASE_W);
            div_divisor    = DIVISOR_W'(period_now);
            div_iterations = COUNT_W'(PHASE_W);
         end
         ST_MODULO: begin
            div_dividend   = '0;
            div_init_rem   = div_remainder;
            div_divisor    = DIVISOR_W'(period_ff);
            div_iterations = COUNT_W'(FB);
         end
         default: begin
         end
      endcase
   end

   // Wave datapath; it runs freely and settles while the sequencer counts through it.
   always_comb begin
      pos_prod = POSMUL_W'(frac_ff) * POSMUL_W'(4 * SINE_TABLE_DEPTH);
      pos_in   = POS_W'(pos_prod >> FB);

      if (pos_ff >= POS_W'(3 * SINE_TABLE_DEPTH)) begin
         rom_addr_in = IDX_W'(POS_W'(4 * SINE_TABLE_DEPTH) - pos_ff);
         neg_in      = 1'b1;
      end else if (pos_ff >= POS_W'(2 * SINE_TABLE_DEPTH)) begin
         rom_addr_in = IDX_W'(pos_ff - POS_W'(2 * SINE_TABLE_DEPTH));
         neg_in      = 1'b1;
      end else if (pos_ff >= POS_W'(SINE_TABLE_DEPTH)) begin
         rom_addr_in = IDX_W'(POS_W'(2 * SINE_TABLE_DEPTH) - pos_ff);
         neg_in      = 1'b0;
      end else begin
         rom_addr_in = IDX_W'(pos_ff);
         neg_in      = 1'b0;
      end

      sine_q15 = neg_ff ? -$signed({1'b0, rom_data_ff}) : $signed({1'b0, rom_data_ff});

      saw_v   = $signed({1'b0, frac_ff, 1'b0} - FULL);
      tri_abs = saw_v[V_W-1] ? -saw_v : saw_v;
      tri_v   = $signed((tri_abs << 1) - FULL);

      // Scale to Q.15, truncating towards zero.
      saw_scaled = $signed({saw_v, 15'b0});
      tri_scaled = $signed({tri_v, 15'b0});
      saw_biased = saw_scaled + $signed(saw_scaled[SCL_W-1] ? TRUNC_ADJ : '0);
      tri_biased = tri_scaled + $signed(tri_scaled[SCL_W-1] ? TRUNC_ADJ : '0);
      saw_q15    = $signed(saw_biased[FB+16:FB]);
      tri_q15    = $signed(tri_biased[FB+16:FB]);

      case (wave_ff)
         WAVE_SINE:     value_in = sine_q15;
         WAVE_TRIANGLE: value_in = tri_q15;
         WAVE_SAWTOOTH: value_in = saw_q15;
         default:       value_in = '0;
      endcase

      prod_in = value_ff * gain_ff;

      prod_biased = prod_ff + $signed(prod_ff[PROD_W-1] ? PROD_W'(4095) : PROD_W'(0));
      prod_div    = $signed(prod_biased[PROD_W-1:12]);
      if (prod_div > $signed((PROD_W-12)'(32767))) begin
         sample_sat = 16'sh7FFF;
      end else if (prod_div < -$signed((PROD_W-12)'(32768))) begin
         sample_sat = 16'sh8000;
      end else begin
         sample_sat = prod_div[SAMPLE_W-1:0];
      end
   end

   // Configuration registers.
   always_comb begin
      freq_in = freq_ff;
      gain_in = gain_ff;
      wave_in = wave_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_FREQ: freq_in = csr_data[FREQ_W-1:0];
            CSR_GAIN: gain_in = $signed(csr_data[GAIN_W-1:0]);
            CSR_WAVE: wave_in = csr_data[WAVE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Sequencer.
   always_comb begin
      state_in       = state_ff;
      div_start      = 1'b0;
      phase_in       = phase_ff;
      period_in      = period_ff;
      silent_in      = silent_ff;
      frac_in        = frac_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_payload.req_type == REQ_LOAD) begin
                  phase_in  = req_payload.new_phase;
                  silent_in = 1'b1;
                  state_in  = ST_RESULT;
               end else if (freq_ff == '0) begin
                  silent_in = 1'b1;
                  state_in  = ST_RESULT;
               end else begin
                  silent_in = 1'b0;
                  div_start = 1'b1;
                  state_in  = ST_PERIOD;
               end
            end
         end
         ST_PERIOD: begin
            if (div_done) begin
               period_in = period_now;
               if (period_now == '0) begin
                  silent_in = 1'b1;
                  state_in  = ST_RESULT;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_MODULO;
               end
            end
         end
         ST_MODULO: begin
            if (div_done) begin
               phase_in  = PHASE_W'(phase_next);
               div_start = 1'b1;
               state_in  = ST_FRACTION;
            end
         end
         ST_FRACTION: begin
            if (div_done) begin
               frac_in  = div_quotient[FB-1:0];
               state_in = ST_POSITION;
            end
         end
         ST_POSITION: state_in = ST_QUADRANT;
         ST_QUADRANT: state_in = ST_LOOKUP;
         ST_LOOKUP:   state_in = ST_VALUE;
         ST_VALUE:    state_in = ST_SCALE;
         ST_SCALE:    state_in = ST_RESULT;
         ST_RESULT: begin
            // The item waits here until the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in              = 1'b1;
               rsp_payload_in.sample_out = silent_ff ? '0 : sample_sat;
               rsp_payload_in.phase_now  = phase_ff;
               state_in                  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         freq_ff      <= FREQ_RESET;
         gain_ff      <= GAIN_RESET;
         wave_ff      <= WAVE_RESET;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         freq_ff      <= freq_in;
         gain_ff      <= gain_in;
         wave_ff      <= wave_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      period_ff      <= period_in;
      silent_ff      <= silent_in;
      frac_ff        <= frac_in;
      pos_ff         <= pos_in;
      rom_addr_ff    <= rom_addr_in;
      neg_ff         <= neg_in;
      rom_data_ff    <= SineRom[rom_addr_ff];
      value_ff       <= value_in;
      prod_ff        <= prod_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire
